// ----- rtl/fvc_pkg.sv -----
// ----------------------------------------------------------------------------
// fvc_pkg
// shared constants, codes and control types of the valid-mode fir filter
// ----------------------------------------------------------------------------
`default_nettype none

package fvc_pkg;

  // default build of the filter
  localparam int unsigned DEF_MAX_TAPS    = 15;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_COEF_BITS   = 16;

  // width of the filtered result as seen on the port
  localparam int unsigned RESULT_BITS = 35;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration registers
  localparam int unsigned CFG_INDEX_BITS  = 1;
  localparam int unsigned RESET_TAP_COUNT = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TAP_COUNT = 1'b0,
    REG_SYMMETRIC = 1'b1
  } cfg_reg_t;

  // item function codes
  typedef enum logic {
    FUNC_SAMPLE    = 1'b0,
    FUNC_COEF_LOAD = 1'b1
  } func_t;

  // back-side occupancy seen by the front
  typedef struct packed {
    logic queue_full;
    logic queue_empty;
    logic head_busy;
  } flow_t;

endpackage

`default_nettype wire

// ----- rtl/fvc_front.sv -----
// ----------------------------------------------------------------------------
// fvc_front
// accepts items, holds config, delay line and fill count, issues windows
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_front
  import fvc_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = DEF_MAX_TAPS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         item_valid,
  output logic                                         item_ready,
  input  logic                                         func,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_index,
  input  logic signed [((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS)-1:0] value,
  input  logic                                         start_of_signal,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]                    cfg_index,
  input  logic [$clog2(MAX_TAPS + 1)-1:0]              cfg_data,
  input  flow_t                                        flow,
  output logic                                         push,
  output logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]         window_next,
  output logic                                         coef_we,
  output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_waddr,
  output logic signed [COEF_BITS-1:0]                  coef_wdata,
  output logic [$clog2(MAX_TAPS + 1)-1:0]              taps,
  output logic                                         symmetric
);

  localparam int unsigned TAP_BITS = $clog2(MAX_TAPS + 1);
  localparam int unsigned IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [TAP_BITS-1:0] MAX_CNT   = TAP_BITS'(MAX_TAPS);
  localparam logic [IDX_BITS:0]   TAP_LIMIT = (IDX_BITS + 1)'(MAX_TAPS);

  logic [TAP_BITS-1:0]                 tap_count;
  logic                                symmetric_mode;
  logic [TAP_BITS-1:0]                 fill_count;
  logic [TAP_BITS-1:0]                 fill_base;
  logic [TAP_BITS-1:0]                 fill_next;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] sample_window;
  logic                                is_sample;
  logic                                produce;
  logic                                accept;

  // clamp tap count into 1..MAX_TAPS
  always_comb begin
    priority if (tap_count == '0) begin
      taps = TAP_BITS'(1);
    end else if (tap_count > MAX_CNT) begin
      taps = MAX_CNT;
    end else begin
      taps = tap_count;
    end
  end

  assign symmetric = symmetric_mode;

  // fill count restarts on a start mark and saturates at the line depth
  always_comb begin
    fill_base = start_of_signal ? '0 : fill_count;
    fill_next = (fill_base < MAX_CNT) ? fill_base + TAP_BITS'(1) : fill_base;
    produce   = (fill_next >= taps);
    is_sample = (func == FUNC_SAMPLE);
  end

  // newest sample at position 0
  always_comb begin
    window_next[0] = value[SAMPLE_BITS-1:0];
    for (int k = 1; k < MAX_TAPS; k++) begin
      window_next[k] = sample_window[k-1];
    end
  end

  // coefficient loads wait until no queued window can see the store change
  assign item_ready = is_sample ? (!produce || !flow.queue_full)
                                : (flow.queue_empty && !flow.head_busy);
  assign accept     = item_valid && item_ready;
  assign push       = accept && is_sample && produce;
  assign coef_we    = accept && !is_sample && ({1'b0, coef_index} < TAP_LIMIT);
  assign coef_waddr = coef_index;
  assign coef_wdata = value[COEF_BITS-1:0];
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      tap_count      <= TAP_BITS'(RESET_TAP_COUNT);
      symmetric_mode <= 1'b0;
      sample_window  <= '0;
    end else begin
      if (accept && is_sample) begin
        fill_count    <= fill_next;
        sample_window <= window_next;
      end
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TAP_COUNT: tap_count      <= cfg_data;
          REG_SYMMETRIC: symmetric_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fvc_queue.sv -----
// ----------------------------------------------------------------------------
// fvc_queue
// short register queue of sample windows between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_queue
  import fvc_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_MAX_TAPS * DEF_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(QUEUE_DEPTH);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign rdata = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fvc_back.sv -----
// ----------------------------------------------------------------------------
// fvc_back
// operand fold, tap multipliers, registered adder tree and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_back
  import fvc_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = DEF_MAX_TAPS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     queue_empty,
  input  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]     window,
  output logic                                     pop,
  output logic                                     head_busy,
  input  logic [$clog2(MAX_TAPS + 1)-1:0]          taps,
  input  logic                                     symmetric,
  input  logic                                     coef_we,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_waddr,
  input  logic signed [COEF_BITS-1:0]              coef_wdata,
  output logic                                     result_valid,
  input  logic                                     result_ready,
  output logic signed [RESULT_BITS-1:0]            filtered_value
);

  localparam int unsigned TAP_BITS   = $clog2(MAX_TAPS + 1);
  localparam int unsigned IDX_BITS   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned OP_BITS    = SAMPLE_BITS + 1;
  localparam int unsigned PROD_BITS  = OP_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS   = PROD_BITS + $clog2(MAX_TAPS + 1);
  localparam int unsigned SUM_BITS   = (ACC_BITS > RESULT_BITS) ? ACC_BITS : RESULT_BITS;
  localparam int unsigned GROUP_SIZE = 4;
  localparam int unsigned GROUPS     = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

  logic signed [COEF_BITS-1:0]          coefs     [MAX_TAPS];
  logic [TAP_BITS-1:0]                  half;
  logic [MAX_TAPS-1:0][TAP_BITS-1:0]    far_pos;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] far_smp;
  logic signed [OP_BITS-1:0]            op_next   [MAX_TAPS];
  logic signed [OP_BITS-1:0]            ops       [MAX_TAPS];
  logic signed [PROD_BITS-1:0]          prod_next [MAX_TAPS];
  logic signed [PROD_BITS-1:0]          prods     [MAX_TAPS];
  logic signed [SUM_BITS-1:0]           grp_next  [GROUPS];
  logic signed [SUM_BITS-1:0]           grps      [GROUPS];
  logic signed [SUM_BITS-1:0]           total;
  logic                                 en;
  logic                                 s1_valid;
  logic                                 s2_valid;
  logic                                 s3_valid;

  assign en        = !result_valid || result_ready;
  assign pop       = en && !queue_empty;
  assign head_busy = s1_valid;

  // lane j sees x[i+j], the sample j steps after the oldest in the window
  always_comb begin
    half = taps >> 1;
    for (int j = 0; j < MAX_TAPS; j++) begin
      far_pos[j] = taps - TAP_BITS'(j + 1);
      far_smp[j] = window[far_pos[j][IDX_BITS-1:0]];
      if (symmetric) begin
        if (TAP_BITS'(j) < half) begin
          op_next[j] = OP_BITS'(signed'(far_smp[j])) + OP_BITS'(signed'(window[j]));
        end else if ((TAP_BITS'(j) == half) && taps[0]) begin
          op_next[j] = OP_BITS'(signed'(far_smp[j]));
        end else begin
          op_next[j] = '0;
        end
      end else begin
        op_next[j] = (TAP_BITS'(j) < taps) ? OP_BITS'(signed'(far_smp[j])) : '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      prod_next[j] = ops[j] * coefs[j];
    end
  end

  // first tree level: groups of four products
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_TAPS) begin
          grp_next[g] = grp_next[g] + SUM_BITS'(prods[g * GROUP_SIZE + k]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + grps[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        coefs[j] <= '0;
      end
    end else if (coef_we) begin
      coefs[coef_waddr] <= coef_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= !queue_empty;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops            <= op_next;
      prods          <= prod_next;
      grps           <= grp_next;
      filtered_value <= total[RESULT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fir_valid_convolution.sv -----
// ----------------------------------------------------------------------------
// fir_valid_convolution
// valid-mode direct-form fir filter with coefficient loading and folding
// ----------------------------------------------------------------------------
// The filter takes one item per clock while item_ready is high. A sample
// item shifts the delay line; once tap_count samples have arrived since the
// last start_of_signal mark it yields the exact sum of tap products, 35 bits
// signed, past the window queue, alignment and folding into the operand
// register, the tap multipliers, the registered adder tree and the result
// register. Earlier samples of a signal yield nothing. A coefficient item
// writes one tap if its index is in range and yields nothing; it is accepted
// only once every queued window has passed the multiplier stage, so after a
// producing sample it is held off while that window is in the queue or
// operand register, and longer while a result waiting on result_ready
// stalls the pipeline. The result register and a two-entry window queue let
// new samples flow in while a finished result waits on result_ready.
// Configuration writes are always accepted and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_valid_convolution
  import fvc_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = DEF_MAX_TAPS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // item channel
  input  logic                                         item_valid,
  output logic                                         item_ready,
  input  logic                                         func,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_index,
  input  logic signed [((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS)-1:0] value,
  input  logic                                         start_of_signal,
  // result channel
  output logic                                         result_valid,
  input  logic                                         result_ready,
  output logic signed [RESULT_BITS-1:0]                filtered_value,
  // configuration channel
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]                    cfg_index,
  input  logic [$clog2(MAX_TAPS + 1)-1:0]              cfg_data
);

  localparam int unsigned TAP_BITS = $clog2(MAX_TAPS + 1);
  localparam int unsigned IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned WIN_BITS = MAX_TAPS * SAMPLE_BITS;

  flow_t                                flow;
  logic                                 push;
  logic                                 pop;
  logic                                 q_empty;
  logic                                 q_full;
  logic                                 head_busy;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] window_next;
  logic [WIN_BITS-1:0]                  q_wdata;
  logic [WIN_BITS-1:0]                  q_rdata;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] head_window;
  logic                                 coef_we;
  logic [IDX_BITS-1:0]                  coef_waddr;
  logic signed [COEF_BITS-1:0]          coef_wdata;
  logic [TAP_BITS-1:0]                  taps;
  logic                                 symmetric;

  // back-side occupancy, used to hold producing samples on a full queue and coefficient loads behind queued windows
  assign flow = '{queue_full: q_full, queue_empty: q_empty, head_busy: head_busy};

  // front: handshake, config registers, delay line and fill count
  fvc_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .func            (func),
    .coef_index      (coef_index),
    .value           (value),
    .start_of_signal (start_of_signal),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .flow            (flow),
    .push            (push),
    .window_next     (window_next),
    .coef_we         (coef_we),
    .coef_waddr      (coef_waddr),
    .coef_wdata      (coef_wdata),
    .taps            (taps),
    .symmetric       (symmetric)
  );

  // full windows of producing samples wait here
  assign q_wdata     = window_next;
  assign head_window = q_rdata;

  fvc_queue #(
    .WIDTH (WIN_BITS)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: fold, multiply, sum, result register
  fvc_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (q_empty),
    .window         (head_window),
    .pop            (pop),
    .head_busy      (head_busy),
    .taps           (taps),
    .symmetric      (symmetric),
    .coef_we        (coef_we),
    .coef_waddr     (coef_waddr),
    .coef_wdata     (coef_wdata),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .filtered_value (filtered_value)
  );

endmodule

`default_nettype wire

// ----- rtl/fvc_checker.sv -----
// ----------------------------------------------------------------------------
// fvc_checker
// port-level checks of the fir filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fvc_checker
  import fvc_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = DEF_MAX_TAPS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input logic                                         clk,
  input logic                                         rst,
  input logic                                         item_valid,
  input logic                                         item_ready,
  input logic                                         func,
  input logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_index,
  input logic signed [((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS)-1:0] value,
  input logic                                         start_of_signal,
  input logic                                         result_valid,
  input logic                                         result_ready,
  input logic signed [RESULT_BITS-1:0]                filtered_value,
  input logic                                         cfg_valid,
  input logic                                         cfg_ready,
  input logic [CFG_INDEX_BITS-1:0]                    cfg_index,
  input logic [$clog2(MAX_TAPS + 1)-1:0]              cfg_data
);

  logic sample_seen;

  // set once any sample transaction has been accepted since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_seen <= 1'b0;
    end else if (item_valid && item_ready && (func == FUNC_SAMPLE)) begin
      sample_seen <= 1'b1;
    end
  end

  // a stalled result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(filtered_value))
    else $error("stalled result changed or dropped");

  // nothing leaves the filter right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a result needs an earlier accepted sample, checked on a delayed copy of sample_seen
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(sample_seen, 4))
    else $error("result appeared without an earlier sample");

  // a waiting item transaction keeps its payload
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=>
      item_valid && $stable({func, coef_index, value, start_of_signal}))
    else $error("waiting item changed or dropped");

  // a waiting config write keeps its index and data
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && !cfg_ready |=> cfg_valid && $stable({cfg_index, cfg_data}))
    else $error("waiting config write changed or dropped");

endmodule

bind fir_valid_convolution fvc_checker #(
  .MAX_TAPS    (MAX_TAPS),
  .SAMPLE_BITS (SAMPLE_BITS),
  .COEF_BITS   (COEF_BITS)
) u_fvc_checker (.*);

`default_nettype wire
